[src/aes_pkg.sv]
// ----------------------------------------------------------------------------
// AES-128 package
// Shared widths, S-box, GF(2^8) helpers and the state type of the round chain.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int BlockW = 128;
  localparam int HalfW  = 64;
  localparam int RoundsDef = 10;

  localparam logic [1:0] CfgKeyHigh = 2'd0;
  localparam logic [1:0] CfgKeyLow  = 2'd1;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] r;
    case (x)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] gmul2(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block sits at bits [127-8i -: 8].
  function automatic logic [7:0] byte_of(input logic [BlockW-1:0] v, input int i);
    return v[BlockW-1-8*i -: 8];
  endfunction

  // One beat moving down the chain: block state, round key, round constant.
  typedef struct packed {
    logic              vld;
    logic [BlockW-1:0] st;
    logic [BlockW-1:0] rk;
    logic [7:0]        rc;
  } aes_beat_t;

endpackage

[src/aes128_block_encrypt.sv]
// ----------------------------------------------------------------------------
// AES-128 block encryptor
// Pipelined FIPS-197 AES-128 encryption, one round cell per round.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_valid/cfg_ready/cfg_index/cfg_data write key_high (index 0) and
//   key_low (index 1); other indexes are dropped. cfg_ready is always high.
//   Write the key only while the pipeline is empty.
//   in_valid/in_ready take one plaintext beat; out_valid/out_ready deliver
//   the ciphertext beat in the same order.
//   The ciphertext passes one register for the initial AddRoundKey, then
//   one per round cell, on its way from an accepted input beat to out_valid.
//   Throughput: one block per cycle while the output is not stalled; each
//   round cell does its round and key-schedule step and registers the result.
//   When the receiver stalls with a result pending at the output, the
//   whole chain holds and in_ready drops; otherwise beats keep moving.
//   Reset clears all valid bits and both key registers to zero.
// ----------------------------------------------------------------------------
module aes128_block_encrypt #(
  parameter int ROUNDS = aes_pkg::RoundsDef
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [1:0]               cfg_index,
  input  logic [aes_pkg::HalfW-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [aes_pkg::HalfW-1:0] in_plain_high,
  input  logic [aes_pkg::HalfW-1:0] in_plain_low,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [aes_pkg::HalfW-1:0] out_cipher_high,
  output logic [aes_pkg::HalfW-1:0] out_cipher_low
);
  import aes_pkg::*;

  logic [HalfW-1:0] key_high_r;
  logic [HalfW-1:0] key_low_r;
  aes_beat_t        chain [ROUNDS+1];
  logic             en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgKeyHigh: key_high_r <= cfg_data;
        CfgKeyLow:  key_low_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Chain advances unless the output holds a result the receiver refuses
  assign en       = !chain[ROUNDS].vld || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chain[0].vld <= 1'b0;
    end else if (en) begin
      chain[0].vld <= in_valid;
    end
    if (en) begin
      chain[0].st <= {in_plain_high, in_plain_low} ^ {key_high_r, key_low_r};
      chain[0].rk <= {key_high_r, key_low_r};
      chain[0].rc <= 8'h01;
    end
  end

  for (genvar g = 0; g < ROUNDS; g++) begin : g_round
    aes_round_cell #(
      .LastRound(g == ROUNDS - 1)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .beat_i(chain[g]),
      .beat_o(chain[g+1])
    );
  end

  assign out_valid       = chain[ROUNDS].vld;
  assign out_cipher_high = chain[ROUNDS].st[BlockW-1:HalfW];
  assign out_cipher_low  = chain[ROUNDS].st[HalfW-1:0];

endmodule

[src/aes_round_cell.sv]
// ----------------------------------------------------------------------------
// AES round cell
// One round plus the matching key expansion step, registered at the output.
// ----------------------------------------------------------------------------
module aes_round_cell #(
  parameter bit LastRound = 1'b0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  aes_pkg::aes_beat_t beat_i,
  output aes_pkg::aes_beat_t beat_o
);
  import aes_pkg::*;

  logic [BlockW-1:0] sr;
  logic [BlockW-1:0] mc;
  logic [BlockW-1:0] rk_nxt;
  aes_beat_t         beat_r;

  // SubBytes and ShiftRows; byte index is row + 4 * column
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[BlockW-1-8*(r+4*c) -: 8] = sbox(byte_of(beat_i.st, r + 4*((c + r) & 3)));
      end
    end
  end

  always_comb begin
    logic [7:0] a0, a1, a2, a3, al;
    for (int c = 0; c < 4; c++) begin
      a0 = byte_of(sr, 4*c);
      a1 = byte_of(sr, 4*c+1);
      a2 = byte_of(sr, 4*c+2);
      a3 = byte_of(sr, 4*c+3);
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[BlockW-1-32*c -: 32] = {a0 ^ al ^ gmul2(a0 ^ a1), a1 ^ al ^ gmul2(a1 ^ a2),
                                 a2 ^ al ^ gmul2(a2 ^ a3), a3 ^ al ^ gmul2(a3 ^ a0)};
    end
  end

  // Next round key: RotWord, SubWord and rcon on the last word, then ripple
  always_comb begin
    logic [31:0] t;
    logic [31:0] w;
    w = beat_i.rk[31:0];
    t = {sbox(w[23:16]) ^ beat_i.rc, sbox(w[15:8]), sbox(w[7:0]), sbox(w[31:24])};
    rk_nxt[127:96] = beat_i.rk[127:96] ^ t;
    rk_nxt[95:64]  = beat_i.rk[95:64] ^ rk_nxt[127:96];
    rk_nxt[63:32]  = beat_i.rk[63:32] ^ rk_nxt[95:64];
    rk_nxt[31:0]   = beat_i.rk[31:0] ^ rk_nxt[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.vld <= 1'b0;
    end else if (en) begin
      beat_r.vld <= beat_i.vld;
    end
    if (en) begin
      beat_r.st <= (LastRound ? sr : mc) ^ rk_nxt;
      beat_r.rk <= rk_nxt;
      beat_r.rc <= gmul2(beat_i.rc);
    end
  end

  assign beat_o = beat_r;

endmodule
